// ===== rtl/frx_pkg.sv =====
// ----------------------------------------------------------------------------
// frx_pkg
// Shared types and codes of the checksummed frame receiver.
// ----------------------------------------------------------------------------
package frx_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned STATUS_W  = 3;
    localparam int unsigned TICKS_W   = 16;
    localparam int unsigned INDEX_W   = 9;
    localparam int unsigned HDR_DEPTH = 4;
    localparam int unsigned HDR_AW    = $clog2(HDR_DEPTH);

    localparam logic [TICKS_W-1:0] TIMEOUT_RESET = TICKS_W'(1000);
    localparam logic [TICKS_W-1:0] TICKS_MAX     = '1;

    localparam logic [BYTE_W-1:0] START_ZERO = 8'h00;
    localparam logic [BYTE_W-1:0] START_CODE = 8'hFF;

    // Input command codes.
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Result kinds.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // End-of-frame status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_START = 3'd1;
    localparam logic [STATUS_W-1:0] ST_LEN_SUM   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DATA_SUM  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_ZERO_LEN  = 3'd5;

    typedef struct packed {
        logic              command;
        logic [BYTE_W-1:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic                kind;
        logic [BYTE_W-1:0]   payload_byte;
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   payload_count;
        logic                last;
    } result_t;

    // Handshake between the stages: a held item and whether it moves on.
    typedef struct packed {
        logic valid;
        logic advance;
    } stage_ctl_t;

endpackage

// ===== rtl/frx_if.sv =====
// ----------------------------------------------------------------------------
// frx_if
// Valid/ready channels of the checksummed frame receiver.
// ----------------------------------------------------------------------------
interface frx_item_if
    import frx_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              command;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output command, output rx_byte, input ready);
    modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

interface frx_result_if
    import frx_pkg::*;
;
    logic                valid;
    logic                ready;
    logic                kind;
    logic [BYTE_W-1:0]   payload_byte;
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   payload_count;
    logic                last;

    modport source (output valid, output kind, output payload_byte, output status,
                    output payload_count, output last, input ready);
    modport sink   (input valid, input kind, input payload_byte, input status,
                    input payload_count, input last, output ready);
endinterface

interface frx_cfg_if
    import frx_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [TICKS_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/frx_in_stage.sv =====
// ----------------------------------------------------------------------------
// frx_in_stage
// Input register: holds one accepted item until the parser consumes it.
// ----------------------------------------------------------------------------
module frx_in_stage
    import frx_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    frx_item_if.sink     rx_item,
    input  logic         downstream_ready,
    output stage_ctl_t   ctl,
    output item_t        item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  take;

    assign ctl.valid   = valid_reg;
    assign ctl.advance = valid_reg & downstream_ready;
    assign rx_item.ready = ~valid_reg | downstream_ready;
    assign take        = rx_item.valid & rx_item.ready;
    assign valid_next  = take | (valid_reg & ~downstream_ready);
    assign item        = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.command <= rx_item.command;
            item_reg.rx_byte <= rx_item.rx_byte;
        end
    end

endmodule

// ===== rtl/frx_parser.sv =====
// ----------------------------------------------------------------------------
// frx_parser
// Frame state machine: header check, body checksum, payload and status
// results, per-phase tick timer and the timeout register.
// ----------------------------------------------------------------------------
module frx_parser
    import frx_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    frx_cfg_if.sink    cfg,
    input  stage_ctl_t ctl,
    input  item_t      item,
    output logic       res_valid,
    output result_t    res
);

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_HEADER = 2'd1,
        PH_BODY   = 2'd2
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [INDEX_W-1:0]  byte_index_reg, byte_index_next;
    logic [BYTE_W-1:0]   frame_length_reg, frame_length_next;
    logic [BYTE_W-1:0]   running_sum_reg, running_sum_next;
    logic [TICKS_W-1:0]  tick_count_reg, tick_count_next;
    logic [TICKS_W-1:0]  timeout_reg;
    logic [BYTE_W-1:0]   hdr_reg [HDR_DEPTH];

    logic                hdr_we;
    logic [HDR_AW-1:0]   hdr_addr;
    logic [TICKS_W-1:0]  tick_sat;
    logic [INDEX_W-1:0]  index_m1;
    logic [BYTE_W-1:0]   length_m1;
    logic [BYTE_W-1:0]   emitted;
    logic [BYTE_W-1:0]   b;

    assign cfg.ready = 1'b1;
    assign b         = item.rx_byte;

    assign tick_sat  = (tick_count_reg == TICKS_MAX) ? tick_count_reg
                                                     : tick_count_reg + 1'b1;
    assign index_m1  = byte_index_reg - 1'b1;
    assign length_m1 = frame_length_reg - 1'b1;

    // Payload bytes already delivered in this frame, for a timeout status.
    always_comb
    begin
        emitted = '0;
        if (phase_reg == PH_BODY && byte_index_reg > INDEX_W'(1)
            && frame_length_reg != '0)
        begin
            emitted = (index_m1 < {1'b0, length_m1}) ? index_m1[BYTE_W-1:0]
                                                     : length_m1;
        end
    end

    always_comb
    begin
        phase_next        = phase_reg;
        byte_index_next   = byte_index_reg;
        frame_length_next = frame_length_reg;
        running_sum_next  = running_sum_reg;
        tick_count_next   = tick_count_reg;
        hdr_we            = 1'b0;
        hdr_addr          = byte_index_reg[HDR_AW-1:0];
        res_valid         = 1'b0;
        res               = '0;

        if (ctl.advance)
        begin
            if (item.command == CMD_TICK)
            begin
                if (phase_reg == PH_HEADER || phase_reg == PH_BODY)
                begin
                    if (tick_sat > timeout_reg)
                    begin
                        res_valid         = 1'b1;
                        res.kind          = KIND_STATUS;
                        res.status        = ST_TIMEOUT;
                        res.payload_count = emitted;
                        res.last          = 1'b1;
                        phase_next        = PH_IDLE;
                        byte_index_next   = '0;
                        tick_count_next   = '0;
                        running_sum_next  = '0;
                    end
                    else
                    begin
                        tick_count_next = tick_sat;
                    end
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_HEADER:
                    begin
                        if (!byte_index_reg[HDR_AW])
                        begin
                            hdr_we          = 1'b1;
                            byte_index_next = byte_index_reg + 1'b1;
                        end
                        else
                        begin
                            // Fifth header byte is LCS; check in priority order.
                            res.kind          = KIND_STATUS;
                            res.last          = 1'b1;
                            res.payload_count = '0;
                            byte_index_next   = '0;
                            tick_count_next   = '0;
                            running_sum_next  = '0;
                            if (hdr_reg[0] != START_ZERO || hdr_reg[1] != START_ZERO
                                || hdr_reg[2] != START_CODE)
                            begin
                                res_valid  = 1'b1;
                                res.status = ST_BAD_START;
                                phase_next = PH_IDLE;
                            end
                            else if (BYTE_W'(hdr_reg[3] + b) != '0)
                            begin
                                res_valid  = 1'b1;
                                res.status = ST_LEN_SUM;
                                phase_next = PH_IDLE;
                            end
                            else if (hdr_reg[3] == '0)
                            begin
                                res_valid  = 1'b1;
                                res.status = ST_ZERO_LEN;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                frame_length_next = hdr_reg[3];
                                phase_next        = PH_BODY;
                            end
                        end
                    end
                    PH_BODY:
                    begin
                        if (byte_index_reg <= {1'b0, frame_length_reg})
                        begin
                            running_sum_next = running_sum_reg + b;
                            byte_index_next  = byte_index_reg + 1'b1;
                            if (byte_index_reg != '0
                                && byte_index_reg < {1'b0, frame_length_reg})
                            begin
                                res_valid        = 1'b1;
                                res.kind         = KIND_PAYLOAD;
                                res.payload_byte = b;
                            end
                        end
                        else
                        begin
                            // Postamble: not summed, closes the frame.
                            res_valid         = 1'b1;
                            res.kind          = KIND_STATUS;
                            res.status        = (running_sum_reg == '0) ? ST_OK
                                                                        : ST_DATA_SUM;
                            res.payload_count = length_m1;
                            res.last          = 1'b1;
                            phase_next        = PH_IDLE;
                            byte_index_next   = '0;
                            tick_count_next   = '0;
                            running_sum_next  = '0;
                        end
                    end
                    default:
                    begin
                        // First header byte opens the header phase.
                        hdr_we           = 1'b1;
                        hdr_addr         = '0;
                        phase_next       = PH_HEADER;
                        byte_index_next  = INDEX_W'(1);
                        tick_count_next  = '0;
                        running_sum_next = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            byte_index_reg   <= '0;
            frame_length_reg <= '0;
            running_sum_reg  <= '0;
            tick_count_reg   <= '0;
            timeout_reg      <= TIMEOUT_RESET;
        end
        else
        begin
            phase_reg        <= phase_next;
            byte_index_reg   <= byte_index_next;
            frame_length_reg <= frame_length_next;
            running_sum_reg  <= running_sum_next;
            tick_count_reg   <= tick_count_next;
            if (cfg.valid && cfg.ready)
            begin
                timeout_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (hdr_we)
        begin
            hdr_reg[hdr_addr] <= b;
        end
    end

endmodule

// ===== rtl/frx_out_stage.sv =====
// ----------------------------------------------------------------------------
// frx_out_stage
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module frx_out_stage
    import frx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  stage_ctl_t  ctl,
    input  logic        res_valid,
    input  result_t     res,
    output logic        space,
    frx_result_if.source result
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;
    logic    load;

    assign space      = ~valid_reg | result.ready;
    assign load       = ctl.advance & res_valid;
    assign valid_next = load | (valid_reg & ~result.ready);

    assign result.valid         = valid_reg;
    assign result.kind          = res_reg.kind;
    assign result.payload_byte  = res_reg.payload_byte;
    assign result.status        = res_reg.status;
    assign result.payload_count = res_reg.payload_count;
    assign result.last          = res_reg.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

endmodule

// ===== rtl/checksummed_frame_receiver_top.sv =====
// ----------------------------------------------------------------------------
// checksummed_frame_receiver_top
// Deframer for length- and checksum-protected frames on a byte stream.
// ----------------------------------------------------------------------------
// Each transfer on rx_item is either a received byte or one time tick. The
// block accepts one transfer per clock cycle while the result channel keeps
// up; a transfer passes an input register, the frame state machine and a
// result register on its way to the result channel. While a result waits
// on the result channel, the input register holds and, once it is full,
// rx_item stalls, for bytes and ticks alike. A payload byte produces one
// payload result; the closing postamble, a header error or a phase timeout
// produces one status result with last set. The timeout limit is written
// through cfg and should only change while no frame is in flight.
module checksummed_frame_receiver_top
    import frx_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    frx_item_if.sink     rx_item,
    frx_result_if.source result,
    frx_cfg_if.sink      cfg
);

    stage_ctl_t ctl;
    item_t      item;
    logic       res_valid;
    result_t    res;
    logic       space;

    frx_in_stage u_in_stage (
        .clk              (clk),
        .rst_n            (rst_n),
        .rx_item          (rx_item),
        .downstream_ready (space),
        .ctl              (ctl),
        .item             (item)
    );

    frx_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .ctl       (ctl),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    frx_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .res_valid (res_valid),
        .res       (res),
        .space     (space),
        .result    (result)
    );

endmodule

// ===== tb/tb_checksummed_frame_receiver_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_checksummed_frame_receiver_top
// Self-checking bench for the checksummed frame receiver.
// ----------------------------------------------------------------------------
// A queue of byte and tick transfers feeds a clocked driver. Every accepted
// transfer runs through a local model of the deframer, and the payload and
// status results it predicts wait in order until the monitor sees them. The
// run covers a short list of hand-built frames and then random frames, good
// and broken, under several timeout limits and idle patterns. One stretch
// holds the result channel off long enough for the input to back up.
// ----------------------------------------------------------------------------
module tb_checksummed_frame_receiver_top;
    import frx_pkg::*;

    localparam logic [1:0] RX_IDLE   = 2'd0;
    localparam logic [1:0] RX_HEADER = 2'd1;
    localparam logic [1:0] RX_BODY   = 2'd2;

    // Kinds of frames the random stimulus builds.
    localparam int FR_GOOD      = 0;
    localparam int FR_BAD_DCS   = 1;
    localparam int FR_BAD_START = 2;
    localparam int FR_BAD_LCS   = 3;
    localparam int FR_ZERO_LEN  = 4;
    localparam int FR_TRUNC     = 5;

    localparam int HOLD_CYCLES  = 400;
    localparam int SEGMENTS     = 6;
    localparam int SEG_ITEMS    = 250;
    localparam int SETTLE_CYCLES = 8;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #5 clk = ~clk;

    frx_item_if   rx_item ();
    frx_result_if result ();
    frx_cfg_if    cfg ();

    checksummed_frame_receiver_top uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx_item (rx_item),
        .result  (result),
        .cfg     (cfg)
    );

    item_t   tx_items[$];
    result_t due_results[$];
    int      items_queued = 0;
    int      err_count = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    logic    hold_active = 1'b0;
    event    hold_kick;

    // Local copy of the deframer state.
    logic [1:0]         rx_phase;
    logic [BYTE_W-1:0]  hdr_bytes[HDR_DEPTH];
    logic [INDEX_W-1:0] pos;
    logic [BYTE_W-1:0]  len_q;
    logic [BYTE_W-1:0]  csum;
    logic [TICKS_W-1:0] tick_cnt;
    logic [TICKS_W-1:0] timeout_lim;

    task automatic enter_phase(input logic [1:0] p);
        rx_phase = p;
        pos      = '0;
        tick_cnt = '0;
        csum     = '0;
    endtask

    task automatic reset_deframer();
        timeout_lim = TIMEOUT_RESET;
        len_q       = '0;
        for (int i = 0; i < HDR_DEPTH; i++)
        begin
            hdr_bytes[i] = '0;
        end
        enter_phase(RX_IDLE);
    endtask

    // Payload bytes already emitted in the frame that is in progress.
    function automatic logic [BYTE_W-1:0] payload_so_far();
        logic [INDEX_W-1:0] pay;
        if (rx_phase != RX_BODY || pos <= 1 || len_q == 0)
            return '0;
        pay = {1'b0, len_q} - 9'd1;
        return (pos - 9'd1 < pay) ? BYTE_W'(pos - 9'd1) : BYTE_W'(pay);
    endfunction

    task automatic end_frame(input logic [STATUS_W-1:0] st, input logic [BYTE_W-1:0] cnt);
        result_t r;
        r.kind          = KIND_STATUS;
        r.payload_byte  = '0;
        r.status        = st;
        r.payload_count = cnt;
        r.last          = 1'b1;
        due_results = {due_results, r};
        enter_phase(RX_IDLE);
    endtask

    task automatic predict_deframe(input item_t it);
        result_t            r;
        logic [INDEX_W-1:0] idx;
        if (rx_phase == 2'd3)
            rx_phase = RX_IDLE;
        if (it.command == CMD_TICK)
        begin
            // No timer runs before the first header byte.
            if (rx_phase != RX_IDLE)
            begin
                if (tick_cnt != TICKS_MAX)
                    tick_cnt = tick_cnt + 1'b1;
                if (tick_cnt > timeout_lim)
                    end_frame(ST_TIMEOUT, payload_so_far());
            end
        end
        else
        begin
            if (rx_phase == RX_IDLE)
                enter_phase(RX_HEADER);
            if (rx_phase == RX_HEADER)
            begin
                if (pos < 4)
                begin
                    hdr_bytes[pos[HDR_AW-1:0]] = it.rx_byte;
                    pos = pos + 1'b1;
                end
                else if (hdr_bytes[0] != START_ZERO || hdr_bytes[1] != START_ZERO ||
                         hdr_bytes[2] != START_CODE)
                    end_frame(ST_BAD_START, '0);
                else if (BYTE_W'(hdr_bytes[3] + it.rx_byte) != 0)
                    end_frame(ST_LEN_SUM, '0);
                else if (hdr_bytes[3] == 0)
                    end_frame(ST_ZERO_LEN, '0);
                else
                begin
                    len_q = hdr_bytes[3];
                    enter_phase(RX_BODY);
                end
            end
            else if (pos <= {1'b0, len_q})
            begin
                // TFI, payload and DCS are summed; only the payload is emitted.
                idx  = pos;
                csum = csum + it.rx_byte;
                pos  = pos + 1'b1;
                if (idx >= 1 && idx < {1'b0, len_q})
                begin
                    r.kind          = KIND_PAYLOAD;
                    r.payload_byte  = it.rx_byte;
                    r.status        = ST_OK;
                    r.payload_count = '0;
                    r.last          = 1'b0;
                    due_results = {due_results, r};
                end
            end
            else
                end_frame((csum == 0) ? ST_OK : ST_DATA_SUM, len_q - 8'd1);
        end
    endtask

    task automatic report_mismatch(input string msg);
        err_count++;
        $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    // Driver: one transfer offered at a time, random gaps between them.
    always @(posedge clk or negedge rst_n)
    begin : drive_items
        item_t nxt;
        if (!rst_n)
        begin
            rx_item.valid   <= 1'b0;
            rx_item.command <= CMD_BYTE;
            rx_item.rx_byte <= '0;
        end
        else
        begin
            if (rx_item.valid && rx_item.ready)
            begin
                nxt.command = rx_item.command;
                nxt.rx_byte = rx_item.rx_byte;
                predict_deframe(nxt);
            end
            if (!rx_item.valid || rx_item.ready)
            begin
                if (tx_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = tx_items.pop_front();
                    rx_item.valid   <= 1'b1;
                    rx_item.command <= nxt.command;
                    rx_item.rx_byte <= nxt.rx_byte;
                end
                else
                    rx_item.valid <= 1'b0;
            end
        end
    end

    // Monitor: random stalls, and a long hold when one is requested.
    always @(posedge clk or negedge rst_n)
    begin : watch_results
        result_t want;
        if (!rst_n)
            result.ready <= 1'b0;
        else
        begin
            if (result.valid && result.ready)
            begin
                if (due_results.size() == 0)
                    report_mismatch("result with nothing expected");
                else
                begin
                    want = due_results.pop_front();
                    check_field("kind", 8'(result.kind), 8'(want.kind));
                    check_field("payload_byte", result.payload_byte, want.payload_byte);
                    check_field("status", 8'(result.status), 8'(want.status));
                    check_field("payload_count", result.payload_count, want.payload_count);
                    check_field("last", 8'(result.last), 8'(want.last));
                end
            end
            result.ready <= !hold_active && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(hold_kick)
    begin
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_active = 1'b0;
    end

    task automatic push_byte(input logic [7:0] b);
        item_t it;
        it.command = CMD_BYTE;
        it.rx_byte = b;
        tx_items = {tx_items, it};
        items_queued++;
    endtask

    task automatic push_tick();
        item_t it;
        it.command = CMD_TICK;
        it.rx_byte = 8'($urandom_range(255));
        tx_items = {tx_items, it};
        items_queued++;
    endtask

    task automatic push_header(input logic [39:0] h);
        for (int i = 4; i >= 0; i--)
        begin
            push_byte(h[i*8 +: 8]);
        end
    endtask

    task automatic wait_sent();
        do
            @(negedge clk);
        while (tx_items.size() != 0 || rx_item.valid);
    endtask

    // Brings the block back to idle and waits until every result is in.
    task automatic settle();
        wait_sent();
        while (rx_phase != RX_IDLE)
        begin
            if (rx_phase == RX_HEADER && pos == 4)
                push_byte(~hdr_bytes[3]);
            else
                push_byte(8'($urandom_range(255)));
            wait_sent();
        end
        while (due_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_timeout(input logic [TICKS_W-1:0] v);
        @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.data  <= v;
        do
            @(posedge clk);
        while (cfg.ready !== 1'b1);
        cfg.valid <= 1'b0;
        timeout_lim = v;
    endtask

    task automatic send_frame(input int flavor, input int unsigned len);
        logic [7:0] fb[$];
        logic [7:0] sum;
        logic [7:0] b;
        int         cut;
        int         ph_ticks;
        int         n;
        fb = {START_ZERO, START_ZERO, START_CODE};
        if (flavor == FR_BAD_START)
        begin
            n = $urandom_range(2);
            fb[n] = fb[n] ^ 8'($urandom_range(1, 255));
        end
        if (flavor == FR_ZERO_LEN)
            len = 0;
        fb = {fb, 8'(len)};
        b = 8'd0 - 8'(len);
        if (flavor == FR_BAD_LCS)
            b = b + 8'($urandom_range(1, 255));
        fb = {fb, b};
        if (flavor == FR_GOOD || flavor == FR_BAD_DCS || flavor == FR_TRUNC)
        begin
            // TFI and LEN-1 payload bytes, then DCS and the postamble.
            sum = '0;
            repeat (len)
            begin
                b   = 8'($urandom_range(255));
                sum = sum + b;
                fb = {fb, b};
            end
            b = 8'd0 - sum;
            if (flavor == FR_BAD_DCS)
                b = b + 8'($urandom_range(1, 255));
            fb = {fb, b};
            fb = {fb, 8'($urandom_range(255))};
        end
        cut = fb.size();
        if (flavor == FR_TRUNC)
            cut = $urandom_range(1, fb.size() - 1);
        // Ticks inside a frame stay within the limit of the phase they fall in.
        ph_ticks = 0;
        for (int i = 0; i < cut; i++)
        begin
            if (i == 5)
                ph_ticks = 0;
            if (i > 0 && ph_ticks < int'(timeout_lim) && $urandom_range(15) == 0)
            begin
                push_tick();
                ph_ticks++;
            end
            push_byte(fb[i]);
        end
        if (flavor == FR_TRUNC)
            repeat (int'(timeout_lim) + 1) push_tick();
    endtask

    task automatic random_frame();
        int          r;
        int unsigned len;
        r = $urandom_range(99);
        if (r < 3)
            len = 255;
        else if (r < 10)
            len = $urandom_range(13, 254);
        else
            len = $urandom_range(1, 12);
        r = $urandom_range(99);
        if (r < 60)
            send_frame(FR_GOOD, len);
        else if (r < 70)
            send_frame(FR_BAD_DCS, len);
        else if (r < 77)
            send_frame(FR_BAD_START, $urandom_range(255));
        else if (r < 84)
            send_frame(FR_BAD_LCS, $urandom_range(255));
        else if (r < 89)
            send_frame(FR_ZERO_LEN, 0);
        else if (r < 95)
            send_frame((timeout_lim <= 40) ? FR_TRUNC : FR_GOOD, len);
        else
            repeat (5) push_byte(8'($urandom_range(255)));
        // A few ticks between frames, which the idle block ignores.
        if ($urandom_range(9) == 0)
            repeat ($urandom_range(1, 3)) push_tick();
    endtask

    initial
    begin
        logic [TICKS_W-1:0] seg_limits[SEGMENTS];
        int                 target;
        seg_limits = '{16'd65535, 16'd3, 16'd1000, 16'd40, 16'd0, 16'd0};
        seg_limits[SEGMENTS-1] = TICKS_W'($urandom_range(1, 30));
        rx_item.valid   = 1'b0;
        rx_item.command = CMD_BYTE;
        rx_item.rx_byte = '0;
        result.ready    = 1'b0;
        cfg.valid       = 1'b0;
        cfg.data        = '0;
        reset_deframer();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Hand-built frames under the reset limit: idle tick, shortest good
        // frame, then each header error.
        push_tick();
        push_header(40'h0000FF01FF);
        push_byte(8'hD4);
        push_byte(8'h2C);
        push_byte(8'h00);
        push_header(40'hFF00FF02FE);
        push_header(40'h0000FF0200);
        push_header(40'h0000FF0000);
        settle();

        // A zero limit: one tick ends the header phase, then the body phase.
        write_timeout('0);
        push_byte(8'h00);
        push_tick();
        push_header(40'h0000FF03FD);
        push_byte(8'hD5);
        push_byte(8'hFF);
        push_tick();

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            settle();
            case (seg % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            write_timeout(seg_limits[seg]);
            if (seg == 1)
            begin
                // Long frame against a held-off result channel.
                @(negedge clk);
                -> hold_kick;
                send_frame(FR_GOOD, 200);
            end
            target = items_queued + SEG_ITEMS;
            while (items_queued < target)
                random_frame();
        end
        settle();

        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
